@@ rtl/ptw_pkg.sv @@
package ptw_pkg;

    localparam int PTW_TABLE_PAGES = 16;
    localparam int PTW_ENTRIES     = 512;
    localparam int PTW_IDX_W       = 9;
    localparam int PTW_OFF_W       = 12;
    localparam int PTW_FLAG_W      = 10;
    localparam int PTW_PPN_W       = 44;
    localparam int PTW_PTE_W       = 54;
    localparam int PTW_VA_W        = 39;
    localparam int PTW_PA_W        = 56;
    localparam int PTW_PERM_W      = 8;

    // pte flag positions
    localparam int PTE_V_BIT = 0;
    localparam int PTE_U_BIT = 4;

    typedef enum logic [1:0] {
        KIND_XLATE = 2'd0,
        KIND_MAP   = 2'd1,
        KIND_UNMAP = 2'd2,
        KIND_NONE  = 2'd3
    } ptw_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_MAPPED = 3'd1,
        ST_ALREADY    = 3'd2,
        ST_NO_SPACE   = 3'd3,
        ST_NOT_LEAF   = 3'd4,
        ST_VA_HIGH    = 3'd5,
        ST_OUTSIDE    = 3'd6
    } ptw_status_t;

    typedef enum logic [2:0] {
        PTW_CLEAR,
        PTW_IDLE,
        PTW_READ,
        PTW_EVAL,
        PTW_HOLD
    } ptw_state_t;

    // one access cycle of the table store
    typedef struct packed {
        logic rd;
        logic wr;
        logic alloc;
    } ptw_mem_op_t;

    typedef struct packed {
        ptw_status_t           status;
        logic [PTW_PA_W-1:0]   addr;
    } ptw_result_t;

    function automatic logic [PTW_IDX_W-1:0] level_index(
        input logic [PTW_VA_W-1:0] va,
        input logic [1:0]          level
    );
        logic [PTW_IDX_W-1:0] idx;
        case (level)
            2'd2:    idx = va[38:30];
            2'd1:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/sv39_page_table_walker.sv @@
// sv39 page table walker with a private table store
//
// s_ channel: one transfer per operation (translate, map one page, unmap one page),
// selected by s_tuser. m_ channel: exactly one transfer per input transfer, in order,
// carrying a status code and a physical address.
// cfg_wr_en/cfg_wr_data write the root table ppn; write it only while the block is idle.
//
// timing: a walk that finds every table present holds the walker for the root read
// in the accepting cycle, then the level-2, level-1 and leaf decisions; the result
// enters the output register with the leaf decision when that register is free. each
// table page allocated on a map adds a pointer write and a re-read. kind 3 and
// out-of-range translates load the output register at the accepting edge itself
// when it is free. throughput: one item at a time, set by the three dependent reads
// through the single-port table store with its registered read.
//
// reset: the table store is swept to zero, one entry per cycle; s_tready stays low
// until the sweep ends.
// a stalled m_ side: the result waits in the output register; the next item is
// still accepted and walks, then waits in the walker until the register frees.
module sv39_page_table_walker
    import ptw_pkg::*;
#(
    parameter int TABLE_PAGES = PTW_TABLE_PAGES
) (
    input  logic         aclk,
    input  logic         aresetn,

    // configuration: root table ppn
    input  logic         cfg_wr_en,
    input  logic [43:0]  cfg_wr_data,   // table_base_ppn[43:0]

    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,       // virt_addr[38:0], leaf_ppn[82:39], perm_flags[90:83]
    input  logic [1:0]   s_tuser,       // kind[1:0]

    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata        // status[2:0], phys_addr[58:3]
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int ADDR_W = PAGE_W + PTW_IDX_W;

    logic [PTW_PPN_W-1:0]  base_ppn_reg;
    logic                  m_tvalid_reg;
    ptw_result_t           m_res_reg;

    logic                  out_free;
    logic                  res_valid;
    ptw_result_t           res;
    ptw_mem_op_t           op;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PTW_PTE_W-1:0]  wr_data;
    logic [PAGE_W-1:0]     alloc_page;
    logic [PTW_PTE_W-1:0]  rd_pte;

    // root table location, kept across writes without touching the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_ppn_reg <= '0;
        end else if (cfg_wr_en) begin
            base_ppn_reg <= cfg_wr_data;
        end
    end

    // output register frees when empty or when its transfer completes
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_res_reg.addr, m_res_reg.status};

    // walk sequencer: accepts requests, drives the store, decides the status
    ptw_ctrl #(
        .TABLE_PAGES (TABLE_PAGES),
        .PAGE_W      (PAGE_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_kind     (s_tuser),
        .s_va       (s_tdata[38:0]),
        .s_ppn      (s_tdata[82:39]),
        .s_perm     (s_tdata[90:83]),
        .s_ready    (s_tready),
        .base_ppn   (base_ppn_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .op         (op),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .alloc_page (alloc_page),
        .rd_pte     (rd_pte)
    );

    // table pages, registered read, fresh pages read as zero
    ptw_store #(
        .TABLE_PAGES (TABLE_PAGES),
        .PAGE_W      (PAGE_W),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .alloc_page (alloc_page),
        .rd_pte     (rd_pte)
    );

endmodule

@@ rtl/ptw_store.sv @@
module ptw_store
    import ptw_pkg::*;
#(
    parameter int TABLE_PAGES = PTW_TABLE_PAGES,
    parameter int PAGE_W      = $clog2(TABLE_PAGES),
    parameter int ADDR_W      = PAGE_W + PTW_IDX_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ptw_mem_op_t           op,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [PTW_PTE_W-1:0]  wr_data,
    input  logic [PAGE_W-1:0]     alloc_page,
    output logic [PTW_PTE_W-1:0]  rd_pte
);

    localparam int DEPTH = TABLE_PAGES * PTW_ENTRIES;

    // each word carries a generation bit next to the pte
    logic [PTW_PTE_W:0]     mem [0:DEPTH-1];
    logic [PTW_PTE_W:0]     rd_word_reg;
    logic [PAGE_W-1:0]      rd_page_reg;
    logic [TABLE_PAGES-1:0] alloc_reg;
    logic [PAGE_W-1:0]      wr_page;
    logic                   wr_tag;

    assign wr_page = wr_addr[ADDR_W-1 -: PAGE_W];
    // a page handed out in this cycle already counts as fresh
    assign wr_tag  = alloc_reg[wr_page] | (op.alloc && (alloc_page == wr_page));

    always_ff @(posedge aclk) begin
        if (op.wr) begin
            mem[wr_addr] <= {wr_tag, wr_data};
        end
        if (op.rd) begin
            rd_word_reg <= mem[rd_addr];
            rd_page_reg <= rd_addr[ADDR_W-1 -: PAGE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= '0;
        end else if (op.alloc) begin
            alloc_reg[alloc_page] <= 1'b1;
        end
    end

    // stale generation reads as a zeroed entry
    assign rd_pte = (rd_word_reg[PTW_PTE_W] == alloc_reg[rd_page_reg])
                  ? rd_word_reg[PTW_PTE_W-1:0] : '0;

endmodule

@@ rtl/ptw_ctrl.sv @@
module ptw_ctrl
    import ptw_pkg::*;
#(
    parameter int TABLE_PAGES = PTW_TABLE_PAGES,
    parameter int PAGE_W      = $clog2(TABLE_PAGES),
    parameter int ADDR_W      = PAGE_W + PTW_IDX_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic [1:0]             s_kind,
    input  logic [PTW_VA_W-1:0]    s_va,
    input  logic [PTW_PPN_W-1:0]   s_ppn,
    input  logic [PTW_PERM_W-1:0]  s_perm,
    output logic                   s_ready,
    input  logic [PTW_PPN_W-1:0]   base_ppn,
    input  logic                   out_free,
    output logic                   res_valid,
    output ptw_result_t            res,
    output ptw_mem_op_t            op,
    output logic [ADDR_W-1:0]      rd_addr,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [PTW_PTE_W-1:0]   wr_data,
    output logic [PAGE_W-1:0]      alloc_page,
    input  logic [PTW_PTE_W-1:0]   rd_pte
);

    localparam int DEPTH = TABLE_PAGES * PTW_ENTRIES;
    localparam int NF_W  = $clog2(TABLE_PAGES + 1);

    ptw_state_t             state_reg, state_next;
    ptw_kind_t              kind_reg;
    logic [PTW_VA_W-1:0]    va_reg;
    logic [PTW_PPN_W-1:0]   ppn_reg;
    logic [PTW_PERM_W-1:0]  perm_reg;
    logic [1:0]             level_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [NF_W-1:0]        next_free_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    ptw_result_t            hold_res_reg;

    logic                   done;
    logic                   follow;
    ptw_result_t            fin;
    logic [PTW_PPN_W-1:0]   pte_ppn;
    logic [PTW_PPN_W-1:0]   rel;
    logic                   outside;
    logic                   no_space;
    logic [PTW_PPN_W-1:0]   ptr_ppn;
    logic                   accept;
    logic                   clr_done;

    assign accept   = s_valid && s_ready;
    assign clr_done = clr_cnt_reg == ADDR_W'(DEPTH - 1);
    assign pte_ppn  = rd_pte[PTW_PTE_W-1:PTW_FLAG_W];
    assign rel      = pte_ppn - base_ppn;
    assign outside  = rel >= PTW_PPN_W'(TABLE_PAGES);
    assign no_space = next_free_reg >= NF_W'(TABLE_PAGES);
    assign ptr_ppn  = base_ppn + PTW_PPN_W'(next_free_reg);
    assign alloc_page = next_free_reg[PAGE_W-1:0];

    // store access and result decode
    always_comb begin
        op         = '0;
        rd_addr    = '0;
        wr_addr    = '0;
        wr_data    = '0;
        done       = 1'b0;
        follow     = 1'b0;
        fin.status = ST_OK;
        fin.addr   = '0;
        s_ready    = 1'b0;
        case (state_reg)
            PTW_CLEAR: begin
                op.wr   = 1'b1;
                wr_addr = clr_cnt_reg;
            end
            PTW_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (ptw_kind_t'(s_kind) == KIND_NONE) begin
                        done = 1'b1;
                    end else if (ptw_kind_t'(s_kind) == KIND_XLATE && s_va[38]) begin
                        done       = 1'b1;
                        fin.status = ST_VA_HIGH;
                    end else begin
                        op.rd   = 1'b1;
                        rd_addr = {PAGE_W'(0), level_index(s_va, 2'd2)};
                    end
                end
            end
            PTW_READ: begin
                op.rd   = 1'b1;
                rd_addr = {page_reg, level_index(va_reg, level_reg)};
            end
            PTW_EVAL: begin
                if (level_reg != 2'd0) begin
                    if (rd_pte[PTE_V_BIT]) begin
                        if (outside) begin
                            done       = 1'b1;
                            fin.status = ST_OUTSIDE;
                        end else begin
                            follow  = 1'b1;
                            op.rd   = 1'b1;
                            rd_addr = {rel[PAGE_W-1:0],
                                       level_index(va_reg, level_reg - 2'd1)};
                        end
                    end else if (kind_reg != KIND_MAP) begin
                        done       = 1'b1;
                        fin.status = ST_NOT_MAPPED;
                    end else if (no_space) begin
                        done       = 1'b1;
                        fin.status = ST_NO_SPACE;
                    end else begin
                        op.wr    = 1'b1;
                        op.alloc = 1'b1;
                        wr_addr  = {page_reg, level_index(va_reg, level_reg)};
                        wr_data  = {ptr_ppn, {(PTW_FLAG_W-1){1'b0}}, 1'b1};
                    end
                end else begin
                    done    = 1'b1;
                    wr_addr = {page_reg, level_index(va_reg, 2'd0)};
                    case (kind_reg)
                        KIND_XLATE: begin
                            if (!rd_pte[PTE_V_BIT] || !rd_pte[PTE_U_BIT]) begin
                                fin.status = ST_NOT_MAPPED;
                            end else begin
                                fin.addr = {pte_ppn, va_reg[PTW_OFF_W-1:0]};
                            end
                        end
                        KIND_MAP: begin
                            if (rd_pte[PTE_V_BIT]) begin
                                fin.status = ST_ALREADY;
                            end else begin
                                op.wr   = 1'b1;
                                wr_data = {ppn_reg, 2'b00, perm_reg[PTW_PERM_W-1:1], 1'b1};
                            end
                        end
                        KIND_UNMAP: begin
                            if (!rd_pte[PTE_V_BIT]) begin
                                fin.status = ST_NOT_MAPPED;
                            end else if (rd_pte[PTW_FLAG_W-1:0] == PTW_FLAG_W'(1)) begin
                                fin.status = ST_NOT_LEAF;
                            end else begin
                                op.wr    = 1'b1;
                                fin.addr = {pte_ppn, {PTW_OFF_W{1'b0}}};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PTW_HOLD: begin
            end
            default: begin
            end
        endcase
        res_valid = out_free && (done || state_reg == PTW_HOLD);
        res       = (state_reg == PTW_HOLD) ? hold_res_reg : fin;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PTW_CLEAR: begin
                if (clr_done) begin
                    state_next = PTW_IDLE;
                end
            end
            PTW_IDLE: begin
                if (accept) begin
                    if (done) begin
                        state_next = out_free ? PTW_IDLE : PTW_HOLD;
                    end else begin
                        state_next = PTW_EVAL;
                    end
                end
            end
            PTW_READ: begin
                state_next = PTW_EVAL;
            end
            PTW_EVAL: begin
                if (done) begin
                    state_next = out_free ? PTW_IDLE : PTW_HOLD;
                end else if (op.wr) begin
                    // re-read after the pointer write lands
                    state_next = PTW_READ;
                end
            end
            PTW_HOLD: begin
                if (out_free) begin
                    state_next = PTW_IDLE;
                end
            end
            default: begin
                state_next = PTW_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PTW_CLEAR;
            next_free_reg <= NF_W'(1);
            clr_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == PTW_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (op.alloc) begin
                next_free_reg <= next_free_reg + NF_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= ptw_kind_t'(s_kind);
            va_reg    <= s_va;
            ppn_reg   <= s_ppn;
            perm_reg  <= s_perm;
            level_reg <= 2'd2;
            page_reg  <= '0;
        end else if (follow) begin
            level_reg <= level_reg - 2'd1;
            page_reg  <= rel[PAGE_W-1:0];
        end else if (op.alloc) begin
            level_reg <= level_reg - 2'd1;
            page_reg  <= next_free_reg[PAGE_W-1:0];
        end
        if (done && !out_free) begin
            hold_res_reg <= fin;
        end
    end

    a_no_rd_wr_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(op.rd && op.wr))
        else $error("store read and write in the same cycle");

    a_alloc_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= NF_W'(TABLE_PAGES))
        else $error("allocator ran past the table store");

    a_alloc_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        op.alloc |=> next_free_reg == $past(next_free_reg) + NF_W'(1))
        else $error("allocator did not advance by one page");

    a_eval_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PTW_EVAL) |-> $past(op.rd))
        else $error("entry evaluated without a preceding read");

    a_result_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result issued into a full output register");

endmodule

@@ test/sv39_page_table_walker_tb.sv @@
module sv39_page_table_walker_tb
    import ptw_pkg::*;
();

    localparam int TABLE_PAGES     = PTW_TABLE_PAGES;
    localparam int STORE_DEPTH     = TABLE_PAGES * PTW_ENTRIES;
    // covers the store sweep after reset, which has no transfers
    localparam int WATCHDOG_CYCLES = 40000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int DIRECTED_ROWS   = 21;

    // one operation, with its result typed in where it is obvious
    typedef struct packed {
        ptw_kind_t             kind;
        logic [PTW_VA_W-1:0]   va;
        logic [PTW_PPN_W-1:0]  ppn;
        logic [PTW_PERM_W-1:0] perm;
        logic                  typed;
        ptw_status_t           exp_status;
        logic [PTW_PA_W-1:0]   exp_addr;
    } op_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [43:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;     // virt_addr[38:0], leaf_ppn[82:39], perm_flags[90:83]
    logic [1:0]   s_tuser;     // kind[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;     // status[2:0], phys_addr[58:3]

    // shadow of the walker: table store, bump allocator, root ppn
    logic [PTW_PTE_W-1:0] pte_copy [STORE_DEPTH];
    int                   next_table;
    logic [PTW_PPN_W-1:0] table_base;

    ptw_result_t pending_results[$];
    int          mismatch_count = 0;
    bit          steady = 1'b0;    // no idling on either side while set

    int phase_items [5] = '{700, 400, 300, 200, 200};

    // directed table: extremes, every kind, not-mapped, already, not-leaf and va-high errors
    op_row_t directed_rows [DIRECTED_ROWS] = '{
        // nothing mapped after reset
        '{KIND_XLATE, 39'h00_0000_0000, 44'h0, 8'h00, 1'b1, ST_NOT_MAPPED, 56'h0},
        // top of the 39-bit space and the first address at 2^38
        '{KIND_XLATE, 39'h7F_FFFF_FFFF, 44'h0, 8'h00, 1'b1, ST_VA_HIGH, 56'h0},
        '{KIND_XLATE, 39'h40_0000_0000, 44'h0, 8'h00, 1'b1, ST_VA_HIGH, 56'h0},
        // unused kind with every field at all ones
        '{KIND_NONE, 39'h7F_FFFF_FFFF, 44'hFFF_FFFF_FFFF, 8'hFF, 1'b1, ST_OK, 56'h0},
        '{KIND_UNMAP, 39'h00_0000_0000, 44'h0, 8'h00, 1'b1, ST_NOT_MAPPED, 56'h0},
        // unaligned map, largest ppn, all permissions
        '{KIND_MAP, 39'h00_0000_0ABC, 44'hFFF_FFFF_FFFF, 8'hFF, 1'b0, ST_OK, 56'h0},
        '{KIND_XLATE, 39'h00_0000_0123, 44'h0, 8'h00, 1'b0, ST_OK, 56'h0},
        '{KIND_MAP, 39'h00_0000_0000, 44'h0, 8'h10, 1'b1, ST_ALREADY, 56'h0},
        // leaf with V alone: no user bit, flags look like a pointer
        '{KIND_MAP, 39'h00_0000_1000, 44'h0, 8'h00, 1'b0, ST_OK, 56'h0},
        '{KIND_XLATE, 39'h00_0000_1FFF, 44'h0, 8'h00, 1'b1, ST_NOT_MAPPED, 56'h0},
        '{KIND_UNMAP, 39'h00_0000_1000, 44'h0, 8'h00, 1'b1, ST_NOT_LEAF, 56'h0},
        '{KIND_UNMAP, 39'h00_0000_0FFF, 44'h0, 8'h00, 1'b0, ST_OK, 56'h0},
        '{KIND_XLATE, 39'h00_0000_0000, 44'h0, 8'h00, 1'b1, ST_NOT_MAPPED, 56'h0},
        // highest indices at every level
        '{KIND_MAP, 39'h7F_FFFF_FFFF, 44'hAAA_AAAA_AAAA, 8'h55, 1'b0, ST_OK, 56'h0},
        '{KIND_UNMAP, 39'h7F_FFFF_F000, 44'h0, 8'h00, 1'b0, ST_OK, 56'h0},
        // last translatable page
        '{KIND_MAP, 39'h3F_FFFF_F000, 44'h555_5555_5555, 8'hDA, 1'b0, ST_OK, 56'h0},
        '{KIND_XLATE, 39'h3F_FFFF_FFFF, 44'h0, 8'h00, 1'b0, ST_OK, 56'h0},
        '{KIND_XLATE, 39'h3F_FFFF_E000, 44'h0, 8'h00, 1'b1, ST_NOT_MAPPED, 56'h0},
        '{KIND_MAP, 39'h00_4020_1000, 44'h000_0000_0001, 8'hFF, 1'b0, ST_OK, 56'h0},
        '{KIND_UNMAP, 39'h00_4020_1000, 44'h0, 8'h00, 1'b0, ST_OK, 56'h0},
        '{KIND_UNMAP, 39'h00_4020_1000, 44'h0, 8'h00, 1'b1, ST_NOT_MAPPED, 56'h0}
    };

    sv39_page_table_walker u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // walk levels 2 and 1 of the shadow table; grow allocates missing tables
    function automatic ptw_status_t descend_tables(
        input  logic [PTW_VA_W-1:0] va,
        input  bit                  grow,
        output int                  slot
    );
        int                   page;
        int                   at;
        logic [PTW_PTE_W-1:0] entry;
        logic [PTW_PPN_W-1:0] rel;
        logic [PTW_PPN_W-1:0] ptr_ppn;
        page = 0;
        slot = 0;
        for (int lvl = 2; lvl > 0; lvl--) begin
            at    = page * PTW_ENTRIES + int'(va[PTW_OFF_W + PTW_IDX_W * lvl +: PTW_IDX_W]);
            entry = pte_copy[at];
            if (entry[PTE_V_BIT]) begin
                // any valid entry above the leaf level is a pointer
                rel = entry[PTW_PTE_W-1:PTW_FLAG_W] - table_base;
                if (rel >= 44'(TABLE_PAGES))
                    return ST_OUTSIDE;
                page = int'(rel);
            end else begin
                if (!grow)
                    return ST_NOT_MAPPED;
                // tables taken earlier in this item stay allocated
                if (next_table >= TABLE_PAGES)
                    return ST_NO_SPACE;
                page = next_table;
                next_table++;
                for (int k = 0; k < PTW_ENTRIES; k++)
                    pte_copy[page * PTW_ENTRIES + k] = '0;
                ptr_ppn   = table_base + 44'(page);
                pte_copy[at] = {ptr_ppn, 10'h001};
            end
        end
        slot = page * PTW_ENTRIES + int'(va[PTW_OFF_W +: PTW_IDX_W]);
        return ST_OK;
    endfunction

    // result of one operation, updating the shadow table
    function automatic ptw_result_t predict_walker(
        input ptw_kind_t             kind,
        input logic [PTW_VA_W-1:0]   va,
        input logic [PTW_PPN_W-1:0]  ppn,
        input logic [PTW_PERM_W-1:0] perm
    );
        ptw_result_t          res;
        logic [PTW_PTE_W-1:0] entry;
        int                   slot;
        res.status = ST_OK;
        res.addr   = '0;
        case (kind)
            KIND_XLATE: begin
                if (va[PTW_VA_W-1]) begin
                    res.status = ST_VA_HIGH;
                end else begin
                    res.status = descend_tables(va, 1'b0, slot);
                    if (res.status == ST_OK) begin
                        entry = pte_copy[slot];
                        if (!entry[PTE_V_BIT] || !entry[PTE_U_BIT])
                            res.status = ST_NOT_MAPPED;
                        else
                            res.addr = {entry[PTW_PTE_W-1:PTW_FLAG_W], va[PTW_OFF_W-1:0]};
                    end
                end
            end
            KIND_MAP: begin
                // offset bits play no part in map and unmap
                res.status = descend_tables(va, 1'b1, slot);
                if (res.status == ST_OK) begin
                    if (pte_copy[slot][PTE_V_BIT])
                        res.status = ST_ALREADY;
                    else
                        pte_copy[slot] = {ppn, 2'b00, perm | 8'h01};
                end
            end
            KIND_UNMAP: begin
                res.status = descend_tables(va, 1'b0, slot);
                if (res.status == ST_OK) begin
                    entry = pte_copy[slot];
                    if (!entry[PTE_V_BIT]) begin
                        res.status = ST_NOT_MAPPED;
                    end else if (entry[PTW_FLAG_W-1:0] == 10'h001) begin
                        res.status = ST_NOT_LEAF;
                    end else begin
                        res.addr       = {entry[PTW_PTE_W-1:PTW_FLAG_W], 12'h000};
                        pte_copy[slot] = '0;
                    end
                end
            end
            default: ;
        endcase
        if (res.status != ST_OK)
            res.addr = '0;
        return res;
    endfunction

    // a few indices per level so that walks keep meeting the same tables
    function automatic logic [PTW_IDX_W-1:0] hot_index();
        case ($urandom_range(0, 3))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd2;
            default: return 9'd511;
        endcase
    endfunction

    function automatic op_row_t random_op();
        op_row_t              op;
        int                   roll;
        logic [PTW_IDX_W-1:0] leaf_idx;
        leaf_idx = $urandom_range(0, 1) ? 9'($urandom_range(0, 3)) : 9'($urandom);
        op.va    = {hot_index(), hot_index(), leaf_idx, 12'($urandom)};
        // some noise over the whole address space
        if ($urandom_range(0, 9) == 0)
            op.va = 39'({$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < 35)
            op.kind = KIND_MAP;
        else if (roll < 70)
            op.kind = KIND_XLATE;
        else if (roll < 95)
            op.kind = KIND_UNMAP;
        else
            op.kind = KIND_NONE;
        op.ppn = 44'({$urandom, $urandom});
        // now and then a leaf with V alone
        op.perm       = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        op.typed      = 1'b0;
        op.exp_status = ST_OK;
        op.exp_addr   = '0;
        return op;
    endfunction

    // one request transfer, expectation queued at the accepting edge
    task automatic drive_op(input op_row_t op);
        ptw_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.kind;
        s_tdata  <= {5'd0, op.perm, op.ppn, op.va};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = predict_walker(op.kind, op.va, op.ppn, op.perm);
        if (op.typed) begin
            predicted.status = op.exp_status;
            predicted.addr   = op.exp_addr;
        end
        pending_results.push_back(predicted);
    endtask

    // new root ppn, only once the walker has gone quiet
    task automatic write_table_base(input logic [PTW_PPN_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        // the store keeps its contents across a base change
        table_base = value;
    endtask

    // result side: check each transfer, then pick the next ready
    always @(posedge aclk) begin
        ptw_result_t  want;
        ptw_status_t  got_status;
        logic [55:0]  got_addr;
        if (aresetn && m_tvalid && m_tready) begin
            got_status = ptw_status_t'(m_tdata[2:0]);
            got_addr   = m_tdata[58:3];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer: status %0d, phys_addr %h",
                         $time, got_status, got_addr);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got_status != want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, got_status);
                    mismatch_count++;
                end
                if (got_addr != want.addr) begin
                    $display("%0t: phys_addr mismatch: expected %h, got %h",
                             $time, want.addr, got_addr);
                    mismatch_count++;
                end
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [PTW_PPN_W-1:0] new_base;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_XLATE;
        m_tready    <= 1'b0;
        for (int k = 0; k < STORE_DEPTH; k++)
            pte_copy[k] = '0;
        next_table = 1;
        table_base = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // root at ppn 0; s_tready holds off until the store sweep is over
        write_table_base('0);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            drive_op(directed_rows[i]);

        // phases: base 0, all ones, random, a small shift that aliases old pointers, 0
        for (int p = 0; p < 5; p++) begin
            case (p)
                1:       new_base = '1;
                2:       new_base = 44'({$urandom, $urandom});
                3:       new_base = 44'd3;
                default: new_base = '0;
            endcase
            if (p > 0)
                write_table_base(new_base);
            for (int n = 0; n < phase_items[p]; n++) begin
                steady = (p == 0) && (n >= 300) && (n < 600);
                drive_op(random_op());
            end
            steady = 1'b0;
        end

        // let the last results drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
